// ----- src/cgm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cgm_pkg;

  localparam int POS_W     = 16;
  localparam int COL_W     = 8;
  localparam int PROD_W    = POS_W + COL_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MULT,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } stop_t;

  // commands broadcast to every cell of the stop chain
  typedef struct packed {
    logic  insert;
    logic  rotate;
    stop_t fresh;
  } cell_cmd_t;

  // default ramp after reset
  localparam stop_t STOP_FIRST = '{pos: 16'd0, red: 8'd0, green: 8'd173, blue: 8'd255};
  localparam stop_t STOP_LAST  = '{pos: 16'd65535, red: 8'd255, green: 8'd0, blue: 8'd0};

endpackage

`default_nettype wire

// ----- src/cgm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cgm_cell (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cgm_pkg::stop_t         rst_stop,
  input  wire cgm_pkg::cell_cmd_t     cmd,
  input  wire logic                   live,
  input  wire cgm_pkg::stop_t         left_stop,
  input  wire logic                   left_open,
  input  wire cgm_pkg::stop_t         right_stop,
  output cgm_pkg::stop_t              stop,
  output logic                        open
);
  import cgm_pkg::*;

  // this cell sits at or after the insertion point of the new stop
  assign open = !live || (cmd.fresh.pos < stop.pos);

  // insert shifts the tail right by one, rotate moves every stop left by one
  always_ff @(posedge clk) begin
    if (rst) begin
      stop <= rst_stop;
    end else if (cmd.insert && open) begin
      stop <= left_open ? left_stop : cmd.fresh;
    end else if (cmd.rotate) begin
      stop <= right_stop;
    end
  end

endmodule

`default_nettype wire

// ----- src/cgm_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cgm_lane (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic                       step,
  input  wire logic [cgm_pkg::COL_W-1:0]  cur,
  input  wire logic [cgm_pkg::COL_W-1:0]  prev,
  input  wire logic [cgm_pkg::POS_W-1:0]  num,
  input  wire logic [cgm_pkg::POS_W-1:0]  den,
  output logic      [cgm_pkg::COL_W-1:0]  color
);
  import cgm_pkg::*;

  logic              neg;
  logic [COL_W-1:0]  base;
  logic [COL_W-1:0]  mag;
  logic [PROD_W-1:0] quo;
  logic [POS_W-1:0]  rem;
  logic [POS_W:0]    shifted;
  logic              fits;

  // magnitude of the color difference, sign kept apart
  assign mag = (prev < cur) ? (cur - prev) : (prev - cur);

  // one restoring division step per cycle while step is high
  assign shifted = {rem, quo[PROD_W-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (load) begin
      neg  <= prev < cur;
      base <= cur;
      quo  <= PROD_W'(mag) * PROD_W'(num);
      rem  <= '0;
    end else if (step) begin
      rem <= fits ? POS_W'(shifted - {1'b0, den}) : shifted[POS_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  // quotient never exceeds the color difference, so the sum stays in range
  assign color = neg ? (base - quo[COL_W-1:0]) : (base + quo[COL_W-1:0]);

endmodule

`default_nettype wire

// ----- src/color_gradient_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Piecewise linear color ramp over a sorted table of up to MAX_POINTS color
// stops (16-bit position, 65535 = 1.0, and 8-bit red, green, blue). Action
// clear empties the table, add inserts a stop after all stops of equal or
// lower position (status 2 and the stop dropped when full), lookup returns
// the color interpolated between the enclosing stops, clamped to the end
// colors outside them, or status 1 on an empty table. Every transfer in
// gives exactly one transfer out. After reset the table holds a two-stop
// blue-to-red ramp. Clear, add and unused action codes are answered
// without leaving the idle state. A lookup rotates the whole stop chain
// past its head cell, then runs a multiply, the bit-serial divider and a
// final step to form the result, the last three only when it interpolates.
// One item is worked on at a time; a result held in the output register
// holds off the next input until its own transfer.
module color_gradient_map #(
  parameter int MAX_POINTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] position,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [1:0]       status
);
  import cgm_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int JW = $clog2(MAX_POINTS);

  state_t            state, state_next;
  logic [CW-1:0]     count;
  logic [JW-1:0]     scan_idx;
  logic [STEP_W-1:0] step_cnt;
  logic [POS_W-1:0]  pos_q;
  logic              found;
  logic              first;
  stop_t             cur_stop;
  stop_t             prev_stop;
  logic [POS_W-1:0]  den;

  stop_t             stops [MAX_POINTS];
  logic              opens [MAX_POINTS];
  cell_cmd_t         cmd;

  logic              accept;
  logic              full;
  logic              rotate;
  logic              lane_load;
  logic              lane_step;
  logic              scan_last;
  logic              live_head;
  logic              hit;
  logic              found_now;
  logic              first_now;
  stop_t             cur_now;
  stop_t             prev_now;
  logic [POS_W-1:0]  num;
  logic [COL_W-1:0]  lane_red, lane_green, lane_blue;

  assign accept = in_valid && in_ready;
  assign full   = count == CW'(MAX_POINTS);

  // broadcast to the chain
  assign cmd.insert = accept && (action == ACT_ADD) && !full;
  assign cmd.rotate = rotate;
  assign cmd.fresh  = '{pos: position, red: in_red, green: in_green, blue: in_blue};

  // row of stop cells
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    localparam int RIGHT = (k + 1) % MAX_POINTS;
    stop_t rst_stop;
    stop_t left_stop;
    logic  left_open;

    assign rst_stop  = (k == 0) ? STOP_FIRST : ((k == 1) ? STOP_LAST : '0);
    assign left_stop = (k == 0) ? '0 : stops[(k == 0) ? 0 : k - 1];
    assign left_open = (k == 0) ? 1'b0 : opens[(k == 0) ? 0 : k - 1];

    cgm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .rst_stop   (rst_stop),
      .cmd        (cmd),
      .live       (CW'(k) < count),
      .left_stop  (left_stop),
      .left_open  (left_open),
      .right_stop (stops[RIGHT]),
      .stop       (stops[k]),
      .open       (opens[k])
    );
  end

  // head cell examined during the scan
  assign scan_last = scan_idx == JW'(MAX_POINTS - 1);
  assign live_head = CW'(scan_idx) < count;
  assign hit       = !found && live_head && (pos_q < stops[0].pos);
  assign found_now = found || hit;
  assign first_now = hit ? (scan_idx == '0) : first;
  assign cur_now   = hit ? stops[0] : cur_stop;
  assign prev_now  = (live_head && !found_now) ? stops[0] : prev_stop;

  assign num = cur_stop.pos - pos_q;

  // interpolation lanes
  cgm_lane u_lane_red (
    .clk (clk), .load (lane_load), .step (lane_step),
    .cur (cur_stop.red), .prev (prev_stop.red), .num (num), .den (den),
    .color (lane_red)
  );

  cgm_lane u_lane_green (
    .clk (clk), .load (lane_load), .step (lane_step),
    .cur (cur_stop.green), .prev (prev_stop.green), .num (num), .den (den),
    .color (lane_green)
  );

  cgm_lane u_lane_blue (
    .clk (clk), .load (lane_load), .step (lane_step),
    .cur (cur_stop.blue), .prev (prev_stop.blue), .num (num), .den (den),
    .color (lane_blue)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (action == ACT_LOOKUP) && (count != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = (found_now && !first_now) ? ST_MULT : ST_IDLE;
        end
      end
      ST_MULT: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    rotate    = 1'b0;
    lane_load = 1'b0;
    lane_step = 1'b0;
    case (state)
      ST_IDLE:   in_ready  = !out_valid || out_ready;
      ST_SCAN:   rotate    = 1'b1;
      ST_MULT:   lane_load = 1'b1;
      ST_DIV:    lane_step = 1'b1;
      ST_FINISH: ;
      default:   ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= CW'(2);
    end else begin
      state <= state_next;
      if (accept && (action == ACT_CLEAR)) begin
        count <= '0;
      end else if (cmd.insert) begin
        count <= count + CW'(1);
      end
    end
  end

  // scan and divider bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q     <= position;
      scan_idx  <= '0;
      found     <= 1'b0;
      first     <= 1'b0;
    end else if (state == ST_SCAN) begin
      scan_idx  <= scan_idx + JW'(1);
      found     <= found_now;
      first     <= first_now;
      cur_stop  <= cur_now;
      prev_stop <= prev_now;
    end
    if (state == ST_MULT) begin
      den      <= cur_stop.pos - prev_stop.pos;
      step_cnt <= '0;
    end else if (state == ST_DIV) begin
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && !((action == ACT_LOOKUP) && (count != '0))) begin
        out_valid <= 1'b1;
      end else if ((state == ST_SCAN) && scan_last && !(found_now && !first_now)) begin
        out_valid <= 1'b1;
      end else if (state == ST_FINISH) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_red   <= '0;
      out_green <= '0;
      out_blue  <= '0;
      case (action)
        ACT_ADD:    status <= full ? STATUS_FULL : STATUS_OK;
        ACT_LOOKUP: status <= (count == '0) ? STATUS_EMPTY : STATUS_OK;
        default:    status <= STATUS_OK;
      endcase
    end else if ((state == ST_SCAN) && scan_last) begin
      // below the first stop or at or beyond the last one
      if (found_now) begin
        out_red   <= cur_now.red;
        out_green <= cur_now.green;
        out_blue  <= cur_now.blue;
      end else begin
        out_red   <= prev_now.red;
        out_green <= prev_now.green;
        out_blue  <= prev_now.blue;
      end
    end else if (state == ST_FINISH) begin
      out_red   <= lane_red;
      out_green <= lane_green;
      out_blue  <= lane_blue;
    end
  end

endmodule

`default_nettype wire

// ----- tb/color_ramp_checker.sv -----
`timescale 1ns / 1ps

module color_ramp_checker #(
  parameter int MAX_POINTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] position,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [7:0]  out_red,
  input  wire logic [7:0]  out_green,
  input  wire logic [7:0]  out_blue,
  input  wire logic [1:0]  status,
  output int               errors,
  output int               pending
);
  import cgm_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
  } ramp_color_t;

  // shadow copy of the stop table
  logic [15:0] ramp_pos   [MAX_POINTS];
  logic [7:0]  ramp_red   [MAX_POINTS];
  logic [7:0]  ramp_green [MAX_POINTS];
  logic [7:0]  ramp_blue  [MAX_POINTS];
  int unsigned ramp_count;

  ramp_color_t expected_colors[$];

  // one channel of the linear blend, truncated toward zero
  function automatic logic [7:0] blend_channel(input logic [7:0] cur, input logic [7:0] prev,
                                               input int num, input int den);
    int v;
    if (den <= 0) return cur;
    v = int'(cur) + ((int'(prev) - int'(cur)) * num) / den;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // applies one item to the shadow table and returns its color result
  function automatic ramp_color_t step_ramp(input logic [1:0] act, input logic [15:0] pos,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    ramp_color_t res;
    int unsigned i;
    int unsigned k;
    int num;
    int den;
    res = '0;
    res.status = STATUS_OK;
    case (act)
      ACT_CLEAR: begin
        ramp_count = 0;
      end
      ACT_ADD: begin
        if (ramp_count >= MAX_POINTS) begin
          res.status = STATUS_FULL;
        end else begin
          i = 0;
          while (i < ramp_count && pos >= ramp_pos[i]) i++;
          for (k = ramp_count; k > i; k--) begin
            ramp_pos[k]   = ramp_pos[k-1];
            ramp_red[k]   = ramp_red[k-1];
            ramp_green[k] = ramp_green[k-1];
            ramp_blue[k]  = ramp_blue[k-1];
          end
          ramp_pos[i]   = pos;
          ramp_red[i]   = r;
          ramp_green[i] = g;
          ramp_blue[i]  = b;
          ramp_count++;
        end
      end
      ACT_LOOKUP: begin
        if (ramp_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          i = 0;
          while (i < ramp_count && pos >= ramp_pos[i]) i++;
          if (i == ramp_count) begin
            // at or beyond the last stop
            res.red   = ramp_red[ramp_count-1];
            res.green = ramp_green[ramp_count-1];
            res.blue  = ramp_blue[ramp_count-1];
          end else if (i == 0) begin
            // below the first stop
            res.red   = ramp_red[0];
            res.green = ramp_green[0];
            res.blue  = ramp_blue[0];
          end else begin
            num = int'(ramp_pos[i]) - int'(pos);
            den = int'(ramp_pos[i]) - int'(ramp_pos[i-1]);
            res.red   = blend_channel(ramp_red[i], ramp_red[i-1], num, den);
            res.green = blend_channel(ramp_green[i], ramp_green[i-1], num, den);
            res.blue  = blend_channel(ramp_blue[i], ramp_blue[i-1], num, den);
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // watch both channels, compare results in order
  always @(posedge clk) begin
    ramp_color_t want;
    ramp_color_t got;
    if (rst) begin
      ramp_pos[0]   = STOP_FIRST.pos;
      ramp_red[0]   = STOP_FIRST.red;
      ramp_green[0] = STOP_FIRST.green;
      ramp_blue[0]  = STOP_FIRST.blue;
      ramp_pos[1]   = STOP_LAST.pos;
      ramp_red[1]   = STOP_LAST.red;
      ramp_green[1] = STOP_LAST.green;
      ramp_blue[1]  = STOP_LAST.blue;
      ramp_count = 2;
      expected_colors.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{red: out_red, green: out_green, blue: out_blue, status: status};
        if (expected_colors.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected transfer: r=%0d g=%0d b=%0d status=%0d",
                     $realtime, got.red, got.green, got.blue, got.status);
        end else begin
          want = expected_colors.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: exp r=%0d g=%0d b=%0d st=%0d, got r=%0d g=%0d b=%0d st=%0d",
                       $realtime, want.red, want.green, want.blue, want.status,
                       got.red, got.green, got.blue, got.status);
          end
        end
      end
      if (in_valid && in_ready)
        expected_colors = {expected_colors,
                           step_ramp(action, position, in_red, in_green, in_blue)};
    end
    pending <= expected_colors.size();
  end

endmodule

// ----- tb/tb_color_gradient_map.sv -----
`timescale 1ns / 1ps

module tb_color_gradient_map;
  import cgm_pkg::*;

  localparam int MAX_POINTS     = 8;
  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int LOOKUP_LATENCY = MAX_POINTS + 27;
  localparam int SETTLE_CYCLES  = 2 * LOOKUP_LATENCY;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 125;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [15:0] position;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [1:0]  status;

  int errors;
  int pending;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int items_sent = 0;
  logic [15:0] ramp_marks[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  color_gradient_map #(.MAX_POINTS(MAX_POINTS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .position(position),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .status(status)
  );

  color_ramp_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .position(position),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .status(status),
    .errors(errors), .pending(pending)
  );

  // result side: random stalls, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // offer one item, return at the edge of its transfer
  task automatic send_item(input logic [1:0] act, input logic [15:0] pos,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    position <= pos;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act != ACT_RESERVED) items_sent++;
  endtask

  // stop offering until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic clear_ramp();
    send_item(ACT_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    ramp_marks.delete();
  endtask

  task automatic add_stop(input logic [15:0] pos);
    send_item(ACT_ADD, pos, 8'($urandom), 8'($urandom), 8'($urandom));
    if (ramp_marks.size() < MAX_POINTS + 2) ramp_marks = {ramp_marks, pos};
  endtask

  task automatic look_up(input logic [15:0] pos);
    send_item(ACT_LOOKUP, pos, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // positions biased toward the ends and the neighborhood of known stops
  function automatic logic [15:0] pick_position();
    logic [15:0] p;
    int unsigned sel;
    int unsigned nudge;
    sel = $urandom_range(9);
    if (sel == 0) begin
      p = 16'h0000;
    end else if (sel == 1) begin
      p = 16'hFFFF;
    end else if (sel <= 4 && ramp_marks.size() > 0) begin
      p = ramp_marks[$urandom_range(ramp_marks.size() - 1)];
      nudge = $urandom_range(2);
      if (nudge == 0 && p != 16'h0000) p = p - 16'd1;
      else if (nudge == 2 && p != 16'hFFFF) p = p + 16'd1;
    end else begin
      p = 16'($urandom);
    end
    return p;
  endfunction

  // mostly clear/build/query bursts, some loose items in between
  task automatic random_phase(input int tx_pct, input int rx_pct, input int count);
    int target;
    int n;
    int sel;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(3) != 0) clear_ramp();
        n = $urandom_range(MAX_POINTS + 1, 1);
        repeat (n) add_stop(pick_position());
        n = $urandom_range(10, 2);
        repeat (n) look_up(pick_position());
      end else begin
        sel = $urandom_range(99);
        if (sel < 8) clear_ramp();
        else if (sel < 40) add_stop(pick_position());
        else if (sel < 92) look_up(pick_position());
        else send_item(ACT_RESERVED, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    int k;
    rst      = 1'b1;
    in_valid = 1'b0;
    action   = ACT_CLEAR;
    position = '0;
    in_red   = '0;
    in_green = '0;
    in_blue  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default ramp: ends, middle, just inside
    look_up(16'h0000);
    look_up(16'hFFFF);
    look_up(16'h8000);
    look_up(16'h0001);
    look_up(16'hFFFE);
    // unused action code leaves the table alone
    send_item(ACT_RESERVED, 16'h1234, 8'hFF, 8'hFF, 8'hFF);
    // empty table
    clear_ramp();
    look_up(16'd100);
    // single stop, below and beyond it
    send_item(ACT_ADD, 16'd1000, 8'hFF, 8'hFF, 8'hFF);
    look_up(16'h0000);
    look_up(16'hFFFF);
    // extreme stops, equal positions, fill to full
    send_item(ACT_ADD, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_item(ACT_ADD, 16'hFFFF, 8'hFF, 8'h00, 8'h80);
    send_item(ACT_ADD, 16'd1000, 8'h00, 8'hFF, 8'h00);
    send_item(ACT_ADD, 16'd1000, 8'd10, 8'd20, 8'd30);
    send_item(ACT_ADD, 16'd40000, 8'd128, 8'd128, 8'd128);
    send_item(ACT_ADD, 16'd50000, 8'd1, 8'd2, 8'd3);
    send_item(ACT_ADD, 16'd20000, 8'd200, 8'd100, 8'd50);
    // add on a full table is dropped
    send_item(ACT_ADD, 16'd30000, 8'h55, 8'hAA, 8'h55);
    look_up(16'd1000);
    look_up(16'd999);
    look_up(16'hFFFF);
    look_up(16'd45000);
    look_up(16'd30000);
    drain();

    // long hold-off on the result side while items keep coming
    hold_req = hold_req + 1;
    for (k = 0; k < 12; k++) look_up(16'($urandom));
    drain();

    random_phase(0, 0, PHASE_ITEMS);
    random_phase(64, 0, PHASE_ITEMS);
    random_phase(0, 64, PHASE_ITEMS);
    random_phase(35, 35, PHASE_ITEMS);

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
